### rtl/dtti_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal text to typed integer: shared definitions
// Character codes, target type codes and the range limit of each type.
// ---------------------------------------------------------------------------
package dtti_pkg;

   // ASCII codes that the parser recognises.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   // Target type codes carried on the terminator.
   localparam logic [2:0] NT_I8  = 3'd0;
   localparam logic [2:0] NT_U8  = 3'd1;
   localparam logic [2:0] NT_I16 = 3'd2;
   localparam logic [2:0] NT_U16 = 3'd3;
   localparam logic [2:0] NT_I32 = 3'd4;
   localparam logic [2:0] NT_U32 = 3'd5;
   localparam logic [2:0] NT_I64 = 3'd6;
   localparam logic [2:0] NT_U64 = 3'd7;

   typedef logic [63:0] word_type;

   // Largest unsigned magnitude that fits the width of the given type.
   function automatic word_type type_umax(input logic [2:0] num_type);
      word_type lim;
      case (num_type)
         NT_I8, NT_U8:   lim = 64'h0000_0000_0000_00FF;
         NT_I16, NT_U16: lim = 64'h0000_0000_0000_FFFF;
         NT_I32, NT_U32: lim = 64'h0000_0000_FFFF_FFFF;
         NT_I64, NT_U64: lim = 64'hFFFF_FFFF_FFFF_FFFF;
         default:        lim = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return lim;
   endfunction

endpackage

### rtl/decimal_text_to_typed_integer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal text to typed integer
// Parses an ASCII decimal string, one character per transfer, into a
// range-checked 8/16/32/64-bit signed or unsigned value.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries one character per transfer in req_tdata. A
//   transfer with req_tlast high is the terminator: its character is
//   ignored and req_tuser selects the target type (i8, u8, i16, u16, i32,
//   u32, i64, u64). One optional leading sign is allowed.
//   Only the terminator produces a result on the rsp channel: the typed bit
//   pattern in rsp_tdata (signed types sign-extended, zero on failure) and
//   the ok flag in rsp_tuser.
//   The terminator is held in the input register and its result is then
//   loaded into the result register, which drives rsp_tvalid. Throughput is
//   one character per cycle while no terminator waits for the result
//   register, set by the multiply-by-ten and carry check on the
//   accumulator, which is combinational.
//   Reset clears the accumulator and parser flags and empties both
//   registers. When the receiver stalls, characters keep flowing into the
//   accumulator; a terminator waits in the input register until the result
//   register is free, and req_tready is held low only while it waits.
// ---------------------------------------------------------------------------
module decimal_text_to_typed_integer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_text
   input  logic [2:0]  req_tuser,   // [2:0] num_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [0:0]  rsp_tuser    // [0] ok
);
   import dtti_pkg::*;

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_ch_ff;
   logic       s1_last_ff;
   logic [2:0] s1_type_ff;

   // Parser state.
   word_type accum_ff, accum_in;
   logic     neg_ff, neg_in;
   logic     first_ff, first_in;
   logic     saw_ff, saw_in;
   logic     fail_ff, fail_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff, rsp_value_in;
   logic     rsp_ok_ff, rsp_ok_in;

   logic        out_free;
   logic        s1_adv;
   logic        is_sign;
   logic        is_digit;
   logic [3:0]  digit;
   logic [67:0] prod;
   logic        ovf;
   word_type    umax;
   word_type    smax;
   logic        is_signed;
   logic        range_ok;
   logic        good;

   // Handshake: a character always advances, a terminator needs a free result slot.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s1_adv      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_ch_ff   <= req_tdata;
         s1_last_ff <= req_tlast;
         s1_type_ff <= req_tuser;
      end
   end

   // Character classification and accumulator times ten plus digit.
   assign is_sign  = first_ff && ((s1_ch_ff == CH_MINUS) || (s1_ch_ff == CH_PLUS));
   assign is_digit = s1_ch_ff inside {[CH_ZERO:CH_NINE]};
   assign digit    = s1_ch_ff[3:0];
   assign prod     = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                     + {64'd0, digit};
   assign ovf      = |prod[67:64];

   // Next parser state.
   always_comb begin
      accum_in = accum_ff;
      neg_in   = neg_ff;
      first_in = first_ff;
      saw_in   = saw_ff;
      fail_in  = fail_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            accum_in = '0;
            neg_in   = 1'b0;
            first_in = 1'b1;
            saw_in   = 1'b0;
            fail_in  = 1'b0;
         end else if (!fail_ff) begin
            first_in = 1'b0;
            if (is_sign) begin
               neg_in = (s1_ch_ff == CH_MINUS);
            end else if (!is_digit || ovf) begin
               fail_in = 1'b1;
            end else begin
               accum_in = prod[63:0];
               saw_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         neg_ff   <= 1'b0;
         first_ff <= 1'b1;
         saw_ff   <= 1'b0;
         fail_ff  <= 1'b0;
      end else begin
         accum_ff <= accum_in;
         neg_ff   <= neg_in;
         first_ff <= first_in;
         saw_ff   <= saw_in;
         fail_ff  <= fail_in;
      end
   end

   // Range check against the requested type on the terminator.
   assign umax      = type_umax(s1_type_ff);
   assign smax      = umax >> 1;
   assign is_signed = !s1_type_ff[0];

   always_comb begin
      if (is_signed) begin
         if (neg_ff) begin
            range_ok = (accum_ff <= smax + 64'd1);
         end else begin
            range_ok = (accum_ff <= smax);
         end
      end else begin
         range_ok = !neg_ff && (accum_ff <= umax);
      end
   end

   assign good = !fail_ff && saw_ff && range_ok;

   // Result register: loaded by a terminator, emptied by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (s1_adv && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = good;
         if (!good) begin
            rsp_value_in = '0;
         end else if (neg_ff) begin
            rsp_value_in = 64'd0 - accum_ff;
         end else begin
            rsp_value_in = accum_ff;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_ok_ff;

endmodule

### rtl/dtti_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal text to typed integer: port checker
// Watches the top level's channels and checks result stalls, contents and count.
// ---------------------------------------------------------------------------
module dtti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // Terminators taken whose result has not yet been transferred.
   logic [1:0] pending_ff, pending_in;
   logic       term_take;
   logic       rsp_take;

   assign term_take = req_tvalid && req_tready && req_tlast;
   assign rsp_take  = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (term_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!term_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A failed conversion reports a zero value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("failed result carries a non-zero value");

   // No result without an outstanding terminator.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result without a terminator");

   // At most two terminators are held inside the block.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many terminators outstanding");

endmodule

bind decimal_text_to_typed_integer dtti_checker u_dtti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/dtti_conversion_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal text to typed integer: conversion checker
// Watches both stream channels of the parser, keeps its own copy of the
// parse state and works out the typed value and ok flag of every string.
// Each result transfer is compared, field by field, with the oldest
// expected result. Mismatches are counted and handed to the testbench top.
// ---------------------------------------------------------------------------
module dtti_conversion_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_text
   input  logic [2:0]  req_tuser,   // [2:0] num_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] value
   input  logic [0:0]  rsp_tuser,   // [0] ok
   output int          mismatch_count,
   output int          results_owed
);
   import dtti_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        ok;
   } typed_result_type;

   typed_result_type owed_results[$];

   // Parse state of the string currently being received.
   logic [63:0] magnitude;
   logic        minus_seen;
   logic        expecting_sign;
   logic        digit_seen;
   logic        string_bad;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
   end

   // Range check of the finished string against the requested type.
   function automatic typed_result_type range_checked_value(input logic [2:0] num_type);
      typed_result_type res;
      logic [63:0]      umax;
      logic [63:0]      smax;
      logic             is_signed;
      res       = '0;
      umax      = (num_type[2:1] == 2'b11) ? 64'hFFFF_FFFF_FFFF_FFFF
                                           : ((64'd1 << (8 << num_type[2:1])) - 64'd1);
      smax      = umax >> 1;
      is_signed = (num_type[0] == 1'b0);
      if (string_bad || !digit_seen) begin
         return res;
      end
      if (is_signed) begin
         if (minus_seen) begin
            if (magnitude > smax + 64'd1) return res;
            res.value = 64'd0 - magnitude;
         end else begin
            if (magnitude > smax) return res;
            res.value = magnitude;
         end
      end else begin
         if (minus_seen || magnitude > umax) return res;
         res.value = magnitude;
      end
      res.ok = 1'b1;
      return res;
   endfunction

   // Accumulate one character; a non-digit other than a leading sign, or a carry past 64 bits, spoils the string.
   task automatic take_character(input logic [7:0] ch);
      logic [67:0] scaled;
      if (string_bad) begin
         return;
      end
      if (expecting_sign && (ch == CH_MINUS || ch == CH_PLUS)) begin
         minus_seen     = (ch == CH_MINUS);
         expecting_sign = 1'b0;
         return;
      end
      expecting_sign = 1'b0;
      if (ch < CH_ZERO || ch > CH_NINE) begin
         string_bad = 1'b1;
         return;
      end
      scaled = {4'd0, magnitude} * 68'd10 + 68'(ch - CH_ZERO);
      if (scaled[67:64] != 4'd0) begin
         string_bad = 1'b1;
      end else begin
         magnitude  = scaled[63:0];
         digit_seen = 1'b1;
      end
   endtask

   task automatic clear_parse;
      magnitude      = '0;
      minus_seen     = 1'b0;
      expecting_sign = 1'b1;
      digit_seen     = 1'b0;
      string_bad     = 1'b0;
   endtask

   // Track both channels at every rising edge.
   always @(posedge clock) begin
      typed_result_type want;
      if (reset) begin
         clear_parse();
         owed_results.delete();
         results_owed = 0;
      end else begin
         // Result side: compare against the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transfer, expected none, actual value %h ok %b",
                        $time, rsp_tdata, rsp_tuser[0]);
            end else begin
               want = owed_results.pop_front();
               if (rsp_tdata !== want.value) begin
                  mismatch_count++;
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.ok) begin
                  mismatch_count++;
                  $display("%0t: ok flag mismatch, expected %b, actual %b",
                           $time, want.ok, rsp_tuser[0]);
               end
            end
         end
         // Input side: update the parse state, or finish the string.
         if (req_tvalid && req_tready) begin
            if (req_tlast) begin
               owed_results.push_back(range_checked_value(req_tuser));
               clear_parse();
            end else begin
               take_character(req_tdata);
            end
         end
         results_owed = owed_results.size();
      end
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal text to typed integer: testbench top
// Sends directed strings (type limits, signs, empty and broken text) and
// then random strings, mostly well formed and often with values near the type
// limits, with random gaps on both channels and one long receiver stall.
// A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
   import dtti_pkg::*;

   localparam int TEXT_ITEMS     = 1800;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int STALL_CYCLES   = 400;
   localparam int DRAIN_CYCLES   = 10;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   int mismatch_count;
   int results_owed;
   int items_sent  = 0;
   int quiet_count = 0;

   // Steady stretch with no gaps, and the request for one long receiver stall.
   bit no_gaps     = 1'b0;
   bit stall_asked = 1'b0;
   bit stall_taken = 1'b0;
   int stall_left  = 0;

   // Characters of the string being built.
   logic [7:0] text_q[$];

   decimal_text_to_typed_integer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   dtti_conversion_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random back-pressure, one long stall on request.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (stall_asked && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = STALL_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (no_gaps) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // Offer one item and hold it until the transfer takes place.
   task automatic send_item(input logic [7:0] ch, input logic last, input logic [2:0] num_type);
      while (!no_gaps && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      req_tuser  <= num_type;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Send the built string and its terminator; the terminator's character is noise.
   task automatic send_text(input logic [2:0] num_type);
      foreach (text_q[i]) send_item(text_q[i], 1'b0, 3'($urandom_range(0, 7)));
      send_item(8'($urandom_range(0, 255)), 1'b1, num_type);
      text_q.delete();
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic add_decimal(input logic [63:0] v);
      logic [7:0] digits[$];
      do begin
         digits.push_front(CH_ZERO + 8'(v % 64'd10));
         v = v / 64'd10;
      end while (v != 0);
      foreach (digits[i]) text_q.push_back(digits[i]);
   endtask

   function automatic logic [63:0] width_mask(input logic [2:0] num_type);
      if (num_type[2:1] == 2'b11) return 64'hFFFF_FFFF_FFFF_FFFF;
      return (64'd1 << (8 << num_type[2:1])) - 64'd1;
   endfunction

   // Well-formed string, often aimed at a type limit, sometimes spoilt.
   task automatic send_number(input bit spoil);
      logic [2:0]  num_type;
      logic [2:0]  aim_type;
      logic [63:0] lim;
      logic [63:0] mag;
      int          sign_pick;
      num_type  = 3'($urandom_range(0, 7));
      aim_type  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : num_type;
      lim       = width_mask(aim_type);
      sign_pick = $urandom_range(0, 3);
      case ($urandom_range(0, 5))
         0: mag = lim - 64'($urandom_range(0, 2));
         1: mag = (lim >> 1) - 64'd1 + 64'($urandom_range(0, 3));
         2: mag = lim + 64'd1 + 64'($urandom_range(0, 1));
         3: mag = {$urandom, $urandom} & lim;
         4: mag = 64'($urandom_range(0, 999));
         default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      if (sign_pick == 2) text_q.push_back(CH_MINUS);
      if (sign_pick == 3) text_q.push_back(CH_PLUS);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
      end
      add_decimal(mag);
      if ($urandom_range(0, 9) == 0) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (spoil) begin
         text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
      end
      send_text(num_type);
   endtask

   // Short noisy string, weighted towards signs and digits.
   task automatic send_noise;
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 3))
            0: text_q.push_back(CH_MINUS);
            1: text_q.push_back(CH_PLUS);
            2: text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            default: text_q.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      send_text(3'($urandom_range(0, 7)));
   endtask

   // Stimulus and verdict.
   initial begin
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed strings: type limits, signs, empty text and broken text.
      add_str("0");                    send_text(NT_U8);
      add_str("255");                  send_text(NT_U8);
      add_str("256");                  send_text(NT_U8);
      add_str("127");                  send_text(NT_I8);
      add_str("128");                  send_text(NT_I8);
      add_str("-128");                 send_text(NT_I8);
      add_str("-129");                 send_text(NT_I8);
      add_str("+32767");               send_text(NT_I16);
      add_str("-32768");               send_text(NT_I16);
      add_str("65536");                send_text(NT_U16);
      add_str("4294967295");           send_text(NT_U32);
      add_str("-2147483648");          send_text(NT_I32);
      add_str("9223372036854775807");  send_text(NT_I64);
      add_str("-9223372036854775808"); send_text(NT_I64);
      add_str("18446744073709551615"); send_text(NT_U64);
      add_str("18446744073709551616"); send_text(NT_U64);
      add_str("-0");                   send_text(NT_U32);
      add_str("-0");                   send_text(NT_I32);
      send_text(NT_I64);
      add_str("-");                    send_text(NT_I16);
      add_str("+");                    send_text(NT_U64);
      add_str("1-2");                  send_text(NT_I32);
      add_str("--5");                  send_text(NT_I8);
      add_str("x55");                  send_text(NT_U16);
      add_str("12");
      text_q.push_back(8'h00);
      add_str("3");                    send_text(NT_U32);

      // Random strings, with a gap-free stretch and one long receiver stall.
      while (items_sent < TEXT_ITEMS) begin
         if (items_sent >= 600) stall_asked = 1'b1;
         no_gaps = (items_sent >= 1000 && items_sent < 1350);
         pick = $urandom_range(0, 99);
         if (pick < 70)      send_number(1'b0);
         else if (pick < 85) send_number(1'b1);
         else                send_noise();
      end
      no_gaps = 1'b0;
      req_tvalid <= 1'b0;

      // Drain outstanding results, then keep watching for a stray result before the verdict.
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
